### design/rrca_pkg.sv
// Shared types and constants of the round-robin converter channel averager.
`default_nettype none
package rrca_pkg;

  localparam int NUM_CHANNELS  = 4;
  localparam int NUM_REGS      = 4;
  localparam int SAMPLE_WIDTH  = 12;
  localparam int LEN_W         = 8;
  localparam int CH_W          = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int SUM_BITS      = SAMPLE_WIDTH + LEN_W;
  localparam int DIV_CNT_W     = $clog2(SUM_BITS);
  localparam int DEFAULT_LEN   = 16;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } rrca_cmd_t;

  typedef struct packed {
    logic block_done;
    logic out_free;
  } rrca_sts_t;

endpackage
`default_nettype wire

### design/rrca_ctrl.sv
// Controller state machine: request acceptance, divider sequencing, result hand-off.
`default_nettype none
module rrca_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rrca_pkg::rrca_sts_t sts,
  output rrca_pkg::rrca_cmd_t    cmd
);
  import rrca_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIV    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_nxt   = '0;
          state_nxt  = sts.block_done ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + DIV_CNT_W'(1);
        if (step_r == DIV_CNT_W'(SUM_BITS - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

### design/rrca_dp.sv
// Datapath: block lengths, per-channel sums and counts, restoring divider, result register.
`default_nettype none
module rrca_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rrca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rrca_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic [rrca_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output logic [rrca_pkg::CH_W-1:0]           out_sample_channel,
  output logic                                out_block_done,
  output logic [rrca_pkg::SAMPLE_WIDTH-1:0]   out_average,
  output logic [rrca_pkg::CH_W-1:0]           out_next_channel,
  input  wire rrca_pkg::rrca_cmd_t            cmd,
  output rrca_pkg::rrca_sts_t                 sts
);
  import rrca_pkg::*;

  logic [LEN_W-1:0]    block_len_r [NUM_REGS];
  logic [LEN_W-1:0]    block_len_nxt [NUM_REGS];
  logic [SUM_BITS-1:0] sum_r [NUM_CHANNELS];
  logic [SUM_BITS-1:0] sum_nxt [NUM_CHANNELS];
  logic [LEN_W-1:0]    cnt_r [NUM_CHANNELS];
  logic [LEN_W-1:0]    cnt_nxt [NUM_CHANNELS];
  logic [CH_W-1:0]     ptr_r, ptr_nxt;

  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic                done_r, done_nxt;
  logic [CH_W-1:0]     next_r, next_nxt;
  logic [SUM_BITS-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]    dlen_r, dlen_nxt;

  logic                    ovalid_r, ovalid_nxt;
  logic [CH_W-1:0]         och_r, och_nxt;
  logic                    odone_r, odone_nxt;
  logic [SAMPLE_WIDTH-1:0] oavg_r, oavg_nxt;
  logic [CH_W-1:0]         onext_r, onext_nxt;

  logic [CH_W-1:0]     ch;
  logic [LEN_W-1:0]    len_eff;
  logic [SUM_BITS-1:0] sum_acc;
  logic [LEN_W:0]      cnt_acc;
  logic                done_now;
  logic [CH_W-1:0]     ptr_adv;
  logic [LEN_W:0]      trial;
  logic                qbit;
  logic [SAMPLE_WIDTH-1:0] avg_sat;

  // Accumulate step for the current channel.
  always_comb begin
    ch = ptr_r;
    if (32'(ch) >= NUM_CHANNELS) begin
      ch = '0;
    end
    len_eff  = (block_len_r[ch] == '0) ? LEN_W'(1) : block_len_r[ch];
    sum_acc  = sum_r[ch] + SUM_BITS'(in_sample);
    cnt_acc  = {1'b0, cnt_r[ch]} + (LEN_W + 1)'(1);
    done_now = (cnt_acc >= {1'b0, len_eff});
    ptr_adv  = (ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch + CH_W'(1);
  end

  // One quotient bit a step; the remainder always stays below the divisor.
  always_comb begin
    trial = {rem_r, quo_r[SUM_BITS-1]};
    qbit  = (trial >= {1'b0, dlen_r});
  end

  always_comb begin
    if (quo_r[SUM_BITS-1:SAMPLE_WIDTH] != '0) begin
      avg_sat = '1;
    end else begin
      avg_sat = quo_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    block_len_nxt = block_len_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    ch_nxt        = ch_r;
    done_nxt      = done_r;
    next_nxt      = next_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dlen_nxt      = dlen_r;
    ovalid_nxt    = ovalid_r && out_stall;
    och_nxt       = och_r;
    odone_nxt     = odone_r;
    oavg_nxt      = oavg_r;
    onext_nxt     = onext_r;

    if (cfg_we) begin
      block_len_nxt[cfg_index] = cfg_wdata;
    end

    if (cmd.accept) begin
      ch_nxt   = ch;
      done_nxt = done_now;
      quo_nxt  = sum_acc;
      rem_nxt  = '0;
      dlen_nxt = len_eff;
      if (done_now) begin
        sum_nxt[ch] = '0;
        cnt_nxt[ch] = '0;
        ptr_nxt     = ptr_adv;
        next_nxt    = ptr_adv;
      end else begin
        sum_nxt[ch] = sum_acc;
        cnt_nxt[ch] = cnt_acc[LEN_W-1:0];
        ptr_nxt     = ch;
        next_nxt    = ch;
      end
    end

    if (cmd.div_step) begin
      quo_nxt = {quo_r[SUM_BITS-2:0], qbit};
      rem_nxt = qbit ? LEN_W'(trial - {1'b0, dlen_r}) : trial[LEN_W-1:0];
    end

    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
      och_nxt    = ch_r;
      odone_nxt  = done_r;
      oavg_nxt   = done_r ? avg_sat : '0;
      onext_nxt  = next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        block_len_r[i] <= LEN_W'(DEFAULT_LEN);
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      ptr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      block_len_r <= block_len_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    done_r  <= done_nxt;
    next_r  <= next_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dlen_r  <= dlen_nxt;
    och_r   <= och_nxt;
    odone_r <= odone_nxt;
    oavg_r  <= oavg_nxt;
    onext_r <= onext_nxt;
  end

  assign sts.block_done = done_now;
  assign sts.out_free   = !ovalid_r || !out_stall;

  assign out_valid          = ovalid_r;
  assign out_sample_channel = och_r;
  assign out_block_done     = odone_r;
  assign out_average        = oavg_r;
  assign out_next_channel   = onext_r;

endmodule
`default_nettype wire

### design/round_robin_adc_channel_averager.sv
// Top level of the round-robin four-channel converter block averager.
// Each accepted request carries one 12-bit conversion result, credited to the channel that the
// round-robin pointer selects; every request yields exactly one result giving that channel, a
// block-complete flag, the truncated block average (zero unless the block completed) and the
// channel to convert next. A request that completes a block also runs the restoring divider,
// which produces one of the 20 quotient bits per cycle. The result sits in an output register,
// so a stalled result does not hold up the divider, but a new request is only taken once the
// previous result has been loaded into that register. Block lengths are to be written through
// the configuration port while the block is idle, which the block itself does not enforce;
// a length of zero behaves as one, and an average that would exceed the full-scale sample value
// saturates to full scale.
`default_nettype none
module round_robin_adc_channel_averager (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rrca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrca_pkg::LEN_W-1:0]        cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [rrca_pkg::SAMPLE_WIDTH-1:0] in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rrca_pkg::CH_W-1:0]              out_sample_channel,
  output logic                                   out_block_done,
  output logic [rrca_pkg::SAMPLE_WIDTH-1:0]      out_average,
  output logic [rrca_pkg::CH_W-1:0]              out_next_channel
);
  import rrca_pkg::*;

  // Commands from the controller and status back from the datapath.
  rrca_cmd_t cmd;
  rrca_sts_t sts;

  // The controller takes a request only when idle, then runs the divider for a completed
  // block and finally hands the result to the output register once that register is free.
  rrca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the block lengths, the per-channel sums and counts, the channel
  // pointer, the divider and the result register.
  rrca_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample          (in_sample),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_sample_channel (out_sample_channel),
    .out_block_done     (out_block_done),
    .out_average        (out_average),
    .out_next_channel   (out_next_channel),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
`default_nettype wire
